>>> rtl/rti_pkg.sv
// Shared types, codes and constants of the regression tree inference block.
package rti_pkg;

   localparam int NODE_AW   = 8;
   localparam int FEAT_AW   = 6;
   localparam int VAL_W     = 32;
   localparam int HOPS_W    = 16;
   localparam int FUNC_W    = 2;
   localparam int REQ_DW    = 136;
   localparam int RSP_DW    = 32;
   localparam int RSP_UW    = 2;
   localparam int NODES     = 1 << NODE_AW;
   localparam int FEATURES  = 1 << FEAT_AW;

   localparam logic [HOPS_W-1:0] HOPS_RESET = HOPS_W'(1000);

   localparam logic [FUNC_W-1:0] FUNC_NODE_WR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FEAT_WR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PREDICT = 2'd2;

   typedef struct packed {
      logic [1:0]         pad;
      logic               feature_missing;
      logic [VAL_W-1:0]   feature_value;
      logic [FEAT_AW-1:0] feature_index;
      logic [VAL_W-1:0]   node_mean;
      logic               is_leaf;
      logic [NODE_AW-1:0] greater_child;
      logic [NODE_AW-1:0] less_child;
      logic [VAL_W-1:0]   cut_value;
      logic [FEAT_AW-1:0] split_feature;
      logic [NODE_AW-1:0] node_index;
   } req_data_type;

   typedef struct packed {
      logic [FEAT_AW-1:0] feat;
      logic [VAL_W-1:0]   cut;
      logic [NODE_AW-1:0] less;
      logic [NODE_AW-1:0] greater;
      logic               leaf;
      logic [VAL_W-1:0]   mean;
   } node_entry_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             missing;
   } feat_entry_type;

   typedef struct packed {
      logic wr_node;
      logic wr_feat;
      logic start;
      logic node_rd;
      logic feat_rd;
      logic step;
      logic finish_node;
      logic finish_miss;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic leaf;
      logic at_limit;
      logic missing;
      logic out_free;
   } status_type;

endpackage

>>> rtl/rti_datapath.sv
// Datapath: node and feature memories, walk registers, hop limit and result register.
module rti_datapath
   import rti_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [REQ_DW-1:0]  req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_DW-1:0]  rsp_tdata,
   output logic [RSP_UW-1:0]  rsp_tuser,
   input  logic               csr_we,
   input  logic [HOPS_W-1:0]  csr_wdata
);

   req_data_type   req;
   node_entry_type node_wr;
   feat_entry_type feat_wr;
   logic           above;

   node_entry_type node_mem_ff [NODES];
   feat_entry_type feat_mem_ff [FEATURES];
   node_entry_type node_q_ff;
   feat_entry_type feat_q_ff;

   logic [NODE_AW-1:0] cur_node_ff, cur_node_in;
   logic [HOPS_W-1:0]  hops_ff, hops_in;
   logic [HOPS_W-1:0]  max_hops_ff, max_hops_in;

   logic [VAL_W-1:0] res_pred_ff, res_pred_in;
   logic             res_miss_ff, res_miss_in;
   logic             res_limit_ff, res_limit_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic             rsp_miss_ff, rsp_miss_in;
   logic             rsp_limit_ff, rsp_limit_in;

   assign req = req_data_type'(req_tdata);

   always_comb begin
      node_wr.feat    = req.split_feature;
      node_wr.cut     = req.cut_value;
      node_wr.less    = req.less_child;
      node_wr.greater = req.greater_child;
      node_wr.leaf    = req.is_leaf;
      node_wr.mean    = req.node_mean;
      feat_wr.value   = req.feature_value;
      feat_wr.missing = req.feature_missing;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_node) begin
         node_mem_ff[req.node_index] <= node_wr;
      end
      if (cmd.wr_feat) begin
         feat_mem_ff[req.feature_index] <= feat_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.node_rd) begin
         node_q_ff <= node_mem_ff[cur_node_ff];
      end
      if (cmd.feat_rd) begin
         feat_q_ff <= feat_mem_ff[node_q_ff.feat];
      end
   end

   assign above = $signed(feat_q_ff.value) > $signed(node_q_ff.cut);

   always_comb begin
      cur_node_in  = cur_node_ff;
      hops_in      = hops_ff;
      max_hops_in  = max_hops_ff;
      res_pred_in  = res_pred_ff;
      res_miss_in  = res_miss_ff;
      res_limit_in = res_limit_ff;
      if (csr_we) begin
         max_hops_in = csr_wdata;
      end
      if (cmd.start) begin
         cur_node_in = '0;
         hops_in     = '0;
      end
      if (cmd.step) begin
         cur_node_in = above ? node_q_ff.greater : node_q_ff.less;
         hops_in     = hops_ff + HOPS_W'(1);
      end
      if (cmd.finish_node) begin
         res_pred_in  = node_q_ff.mean;
         res_miss_in  = 1'b0;
         res_limit_in = ~node_q_ff.leaf;
      end
      if (cmd.finish_miss) begin
         res_pred_in  = '0;
         res_miss_in  = 1'b1;
         res_limit_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_pred_in  = rsp_pred_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_limit_in = rsp_limit_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_pred_in  = res_pred_ff;
         rsp_miss_in  = res_miss_ff;
         rsp_limit_in = res_limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_node_ff  <= '0;
         hops_ff      <= '0;
         max_hops_ff  <= HOPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_node_ff  <= cur_node_in;
         hops_ff      <= hops_in;
         max_hops_ff  <= max_hops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_pred_ff  <= res_pred_in;
      res_miss_ff  <= res_miss_in;
      res_limit_ff <= res_limit_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_miss_ff  <= rsp_miss_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   always_comb begin
      status.leaf     = node_q_ff.leaf;
      status.at_limit = hops_ff >= max_hops_ff;
      status.missing  = feat_q_ff.missing;
      status.out_free = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pred_ff;
   assign rsp_tuser  = {rsp_limit_ff, rsp_miss_ff};

   a_step_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> hops_ff == $past(hops_ff) + HOPS_W'(1) && $past(!status.at_limit))
      else $error("hop taken past the limit");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a pending transfer");

   a_miss_result_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_miss |=> res_pred_ff == '0 && res_miss_ff && !res_limit_ff)
      else $error("missing-feature result malformed");

endmodule

>>> rtl/rti_ctrl.sv
// Controller: state machine that sequences loads, the tree walk and result hand-off.
module rti_ctrl
   import rti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [FUNC_W-1:0] req_tuser,
   input  status_type        status,
   output cmd_type           cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_NODE_RD  = 5'b00010,
      S_NODE_CHK = 5'b00100,
      S_FEAT_CHK = 5'b01000,
      S_DONE     = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  FUNC_NODE_WR: cmd.wr_node = 1'b1;
                  FUNC_FEAT_WR: cmd.wr_feat = 1'b1;
                  FUNC_PREDICT: begin
                     cmd.start = 1'b1;
                     state_in  = S_NODE_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_NODE_RD: begin
            cmd.node_rd = 1'b1;
            state_in    = S_NODE_CHK;
         end
         S_NODE_CHK: begin
            if (status.leaf || status.at_limit) begin
               cmd.finish_node = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.feat_rd = 1'b1;
               state_in    = S_FEAT_CHK;
            end
         end
         S_FEAT_CHK: begin
            if (status.missing) begin
               cmd.finish_miss = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = S_NODE_RD;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_start_walks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == S_NODE_RD)
      else $error("prediction did not start a walk");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_node, cmd.wr_feat, cmd.start}))
      else $error("conflicting actions on one transfer");

   a_step_reads_node: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> cmd.node_rd)
      else $error("step not followed by node read");

endmodule

>>> rtl/regression_tree_inference.sv
// Top level of the regression tree inference block.
//
//   channel  direction  transfer carries
//   req_     in         tuser: func; tdata: node write, feature write fields
//   rsp_     out        tdata: prediction; tuser: stopped_on_missing, stopped_on_limit
//   csr_     in         max_hops write, no read-back
//
// A node or feature write is done on the transfer that carries it. A prediction makes one
// node memory read and one feature memory read per hop, and its result waits in S_DONE
// while the output register holds a result that is not being taken.
// Synchronous reset sets max_hops to 1000 and empties the output register; the
// memories keep no reset value. The next request is taken once the result sits in
// the output register; a stalled result holds only a finishing prediction.
module regression_tree_inference
   import rti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // node_index, split_feature, cut_value, less_child, greater_child, is_leaf,
   // node_mean, feature_index, feature_value, feature_missing, 2 unused pad bits
   input  logic [REQ_DW-1:0] req_tdata,
   // func
   input  logic [FUNC_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // prediction
   output logic [RSP_DW-1:0] rsp_tdata,
   // stopped_on_missing, stopped_on_limit
   output logic [RSP_UW-1:0] rsp_tuser,
   input  logic              csr_we,
   input  logic [HOPS_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   rti_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

endmodule
